[rtl/csvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_pkg
// shared types and constants of the csv record tokenizer
// ----------------------------------------------------------------------------
package csvt_pkg;

    localparam int BYTE_W     = 8;
    localparam int SLOTS      = 3;
    localparam int SLOT_IDX_W = 2;
    localparam int QDEPTH     = 4;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        KIND_CELL   = 3'd0,
        KIND_FIELD  = 3'd1,
        KIND_RECORD = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_END    = 3'd4
    } result_kind_t;

    // one queue entry: the whole run of results caused by one input byte
    typedef struct packed {
        logic [SLOT_IDX_W-1:0]         cnt;
        result_kind_t [SLOTS-1:0]      kinds;
        logic [BYTE_W-1:0]             cell_byte;
    } run_entry_t;

endpackage

[rtl/csv_record_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// streaming csv tokenizer: one text byte in, a run of up to three results out
// ----------------------------------------------------------------------------
// a byte's run is written into the run queue, then its first result is registered
// throughput: one byte per cycle into the run queue; the output sends one result
//   per cycle while m_tready allows; a byte's n results hold it until all are sent
// input stalls only when the run queue (QUEUE_DEPTH entries) is full
// reset: asynchronous, clears the parse flags, the queue and the output stage
// ----------------------------------------------------------------------------
module csv_record_tokenizer
#(
    parameter int QUEUE_DEPTH = csvt_pkg::QDEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // cell_byte
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast    // run_last
);
    import csvt_pkg::*;

    logic       push, q_full, pop, q_valid;
    run_entry_t push_data, q_data;

    csvt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    csvt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    csvt_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/csvt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_front
// accepts text bytes, tracks the parse flags and builds one result run per byte
// ----------------------------------------------------------------------------
module csvt_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // text_byte
    input  logic                      s_tlast,   // end_of_text
    input  logic                      q_full,
    output logic                      push,
    output csvt_pkg::run_entry_t      push_data
);
    import csvt_pkg::*;

    logic in_quotes_reg, in_quotes_next;
    logic quote_pending_reg, quote_pending_next;
    logic field_opened_quoted_reg, field_opened_quoted_next;
    logic cell_has_text_reg, cell_has_text_next;
    logic row_has_cells_reg, row_has_cells_next;
    logic skip_line_feed_reg, skip_line_feed_next;
    logic error_latched_reg, error_latched_next;

    logic       accept;
    run_entry_t ent;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        logic iq, qp, foq, cht, rhc, slf, err;
        logic handled, unq;
        logic [SLOT_IDX_W-1:0] cnt;
        result_kind_t [SLOTS-1:0] kinds;
        logic [BYTE_W-1:0] cb;

        iq  = in_quotes_reg;
        qp  = quote_pending_reg;
        foq = field_opened_quoted_reg;
        cht = cell_has_text_reg;
        rhc = row_has_cells_reg;
        slf = skip_line_feed_reg;
        err = error_latched_reg;
        handled = 1'b0;
        unq     = 1'b0;
        cnt     = '0;
        kinds   = {SLOTS{KIND_CELL}};
        cb      = '0;

        if (!err)
        begin
            if (slf)
            begin
                slf = 1'b0;
                if (s_tdata == CH_LF)
                    handled = 1'b1;
            end
            if (!handled)
            begin
                if (qp)
                begin
                    qp = 1'b0;
                    if (s_tdata == CH_QUOTE)
                    begin
                        kinds[cnt] = KIND_CELL;
                        cb  = CH_QUOTE;
                        cnt = cnt + 1'b1;
                        cht = 1'b1;
                    end
                    else
                    begin
                        iq  = 1'b0;
                        unq = 1'b1;
                    end
                end
                else if (iq)
                begin
                    if (s_tdata == CH_QUOTE)
                        qp = 1'b1;
                    else
                    begin
                        kinds[cnt] = KIND_CELL;
                        cb  = s_tdata;
                        cnt = cnt + 1'b1;
                        cht = 1'b1;
                    end
                end
                else
                    unq = 1'b1;
            end
            if (unq)
            begin
                priority if (s_tdata == CH_QUOTE)
                begin
                    if (cht || foq)
                    begin
                        kinds[cnt] = KIND_ERROR;
                        cnt = cnt + 1'b1;
                        err = 1'b1;
                    end
                    else
                    begin
                        iq  = 1'b1;
                        foq = 1'b1;
                    end
                end
                else if (s_tdata == CH_COMMA)
                begin
                    kinds[cnt] = KIND_FIELD;
                    cnt = cnt + 1'b1;
                    cht = 1'b0;
                    foq = 1'b0;
                    rhc = 1'b1;
                end
                else if (s_tdata == CH_LF || s_tdata == CH_CR)
                begin
                    kinds[cnt] = KIND_RECORD;
                    cnt = cnt + 1'b1;
                    cht = 1'b0;
                    foq = 1'b0;
                    rhc = 1'b0;
                    slf = (s_tdata == CH_CR);
                end
                else
                begin
                    kinds[cnt] = KIND_CELL;
                    cb  = s_tdata;
                    cnt = cnt + 1'b1;
                    cht = 1'b1;
                end
            end
        end

        if (s_tlast)
        begin
            if (!err)
            begin
                if (qp)
                begin
                    qp = 1'b0;
                    iq = 1'b0;
                end
                if (iq)
                begin
                    kinds[cnt] = KIND_ERROR;
                    cnt = cnt + 1'b1;
                end
                else if (cht || rhc || foq)
                begin
                    kinds[cnt] = KIND_RECORD;
                    cnt = cnt + 1'b1;
                end
            end
            kinds[cnt] = KIND_END;
            cnt = cnt + 1'b1;
            iq  = 1'b0;
            qp  = 1'b0;
            foq = 1'b0;
            cht = 1'b0;
            rhc = 1'b0;
            slf = 1'b0;
            err = 1'b0;
        end

        in_quotes_next           = iq;
        quote_pending_next       = qp;
        field_opened_quoted_next = foq;
        cell_has_text_next       = cht;
        row_has_cells_next       = rhc;
        skip_line_feed_next      = slf;
        error_latched_next       = err;
        ent.cnt       = cnt;
        ent.kinds     = kinds;
        ent.cell_byte = cb;
    end

    assign push      = accept && (ent.cnt != '0);
    assign push_data = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg           <= 1'b0;
            quote_pending_reg       <= 1'b0;
            field_opened_quoted_reg <= 1'b0;
            cell_has_text_reg       <= 1'b0;
            row_has_cells_reg       <= 1'b0;
            skip_line_feed_reg      <= 1'b0;
            error_latched_reg       <= 1'b0;
        end
        else if (accept)
        begin
            in_quotes_reg           <= in_quotes_next;
            quote_pending_reg       <= quote_pending_next;
            field_opened_quoted_reg <= field_opened_quoted_next;
            cell_has_text_reg       <= cell_has_text_next;
            row_has_cells_reg       <= row_has_cells_next;
            skip_line_feed_reg      <= skip_line_feed_next;
            error_latched_reg       <= error_latched_next;
        end
    end

endmodule

[rtl/csvt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_queue
// short fifo of result runs between the front and back parts
// ----------------------------------------------------------------------------
module csvt_queue
#(
    parameter int DEPTH = csvt_pkg::QDEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  csvt_pkg::run_entry_t      push_data,
    output logic                      full,
    input  logic                      pop,
    output logic                      q_valid,
    output csvt_pkg::run_entry_t      q_data
);
    import csvt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/csvt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_back
// unpacks each result run and sends its results one per cycle while m_tready allows
// ----------------------------------------------------------------------------
module csvt_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  csvt_pkg::run_entry_t      q_data,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // cell_byte
    output logic [2:0]                m_tuser,   // result_kind
    output logic                      m_tlast    // run_last
);
    import csvt_pkg::*;

    logic                  busy_reg, busy_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    run_entry_t            work_reg, work_next;
    logic                  valid_reg, valid_next;
    result_kind_t          kind_reg, kind_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic                  last_reg, last_next;

    run_entry_t            cur;
    logic [SLOT_IDX_W-1:0] sel, sel_inc;
    logic                  avail, load, fin;

    assign cur     = busy_reg ? work_reg : q_data;
    assign sel     = busy_reg ? idx_reg : '0;
    assign sel_inc = sel + 1'b1;
    assign avail   = busy_reg || q_valid;
    assign load    = avail && (!valid_reg || m_tready);
    assign fin     = (sel_inc == cur.cnt);
    assign pop     = load && !busy_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        work_next  = work_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            kind_next  = cur.kinds[sel];
            byte_next  = (cur.kinds[sel] == KIND_CELL) ? cur.cell_byte : '0;
            last_next  = fin;
            busy_next  = !fin;
            idx_next   = sel_inc;
            if (!busy_reg)
                work_next = q_data;
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

[bench/csv_record_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer_tb
// self-checking bench: directed and random csv text streams are sent through
// the stream input, every byte is run through a local tokenizer model, and
// each output result is matched in order against the predicted runs
// ----------------------------------------------------------------------------
module csv_record_tokenizer_tb;
    import csvt_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int IDLE_PCT     = 18;
    localparam int HOLD_CYCLES  = 80;
    localparam int TARGET_BYTES = 250;

    typedef struct packed {
        result_kind_t      kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } token_t;

    typedef struct {
        logic [BYTE_W-1:0] text;
        logic              eot;
        logic              drain;
    } text_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    text_item_t        pending_text[$];
    token_t            expected_tokens[$];
    token_t            token_run[$];
    logic [BYTE_W-1:0] stream_buf[$];
    text_item_t        next_item;
    token_t            want;

    // tokenizer model state
    bit inq, qpend, fld_quoted, cell_text, row_cells, crlf_skip, err_seen;

    int unsigned cycles       = 0;
    int unsigned fail_cnt     = 0;
    int unsigned bytes_in     = 0;
    int unsigned streams_in   = 0;
    int unsigned tokens_seen  = 0;
    int unsigned streams_made = 0;
    int unsigned hold_cnt     = 0;
    bit          hold_done    = 1'b0;

    wire calm = (bytes_in >= 120) && (bytes_in < 170);

    csv_record_tokenizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        $display("mismatch at cycle %0d: %s: expected %0h, got %0h",
                 cycles, what, exp_val, got_val);
        fail_cnt++;
    endtask

    // ---------------- tokenizer model ----------------
    task automatic add_token(input result_kind_t k, input logic [BYTE_W-1:0] d);
        token_t t;
        t = '{kind: k, data: d, last: 1'b0};
        if (token_run.size() < SLOTS)
            token_run = {token_run, t};
    endtask

    task automatic close_record();
        add_token(KIND_RECORD, '0);
        cell_text  = 1'b0;
        fld_quoted = 1'b0;
        row_cells  = 1'b0;
    endtask

    task automatic plain_byte(input logic [BYTE_W-1:0] b);
        if (b == CH_QUOTE)
        begin
            if (cell_text || fld_quoted)
            begin
                add_token(KIND_ERROR, '0);
                err_seen = 1'b1;
            end
            else
            begin
                inq        = 1'b1;
                fld_quoted = 1'b1;
            end
        end
        else if (b == CH_COMMA)
        begin
            add_token(KIND_FIELD, '0);
            cell_text  = 1'b0;
            fld_quoted = 1'b0;
            row_cells  = 1'b1;
        end
        else if (b == CH_LF)
        begin
            close_record();
        end
        else if (b == CH_CR)
        begin
            close_record();
            crlf_skip = 1'b1;
        end
        else
        begin
            add_token(KIND_CELL, b);
            cell_text = 1'b1;
        end
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        if (crlf_skip)
        begin
            crlf_skip = 1'b0;
            if (b == CH_LF)
                return;
        end
        if (qpend)
        begin
            qpend = 1'b0;
            if (b == CH_QUOTE)
            begin
                add_token(KIND_CELL, CH_QUOTE);
                cell_text = 1'b1;
                return;
            end
            inq = 1'b0;
            plain_byte(b);
            return;
        end
        if (inq)
        begin
            if (b == CH_QUOTE)
                qpend = 1'b1;
            else
            begin
                add_token(KIND_CELL, b);
                cell_text = 1'b1;
            end
            return;
        end
        plain_byte(b);
    endtask

    task automatic tokenize_byte(input logic [BYTE_W-1:0] b, input logic eot);
        token_run.delete();
        if (!err_seen)
            parse_byte(b);
        if (eot)
        begin
            if (!err_seen)
            begin
                if (qpend)
                begin
                    qpend = 1'b0;
                    inq   = 1'b0;
                end
                if (inq)
                    add_token(KIND_ERROR, '0);
                else if (cell_text || row_cells || fld_quoted)
                    close_record();
            end
            add_token(KIND_END, '0);
            {inq, qpend, fld_quoted, cell_text, row_cells, crlf_skip, err_seen} = '0;
        end
        if (token_run.size() > 0)
            token_run[token_run.size() - 1].last = 1'b1;
        expected_tokens = {expected_tokens, token_run};
    endtask

    // ---------------- stream builders ----------------
    task automatic add_text_byte(input logic [BYTE_W-1:0] b);
        stream_buf = {stream_buf, b};
    endtask

    task automatic flush_stream(input bit drain);
        text_item_t item;
        foreach (stream_buf[i])
        begin
            item = '{text: stream_buf[i],
                     eot: (i == stream_buf.size() - 1),
                     drain: drain && (i == 0)};
            pending_text = {pending_text, item};
        end
        stream_buf.delete();
        streams_made++;
    endtask

    function automatic logic [BYTE_W-1:0] plain_text_byte();
        logic [BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(5))
            0: return CH_QUOTE;
            1: return CH_COMMA;
            2: return CH_LF;
            3: return CH_CR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_field();
        int unsigned len;
        logic [BYTE_W-1:0] b;
        len = $urandom_range(4);
        if ($urandom_range(1))
        begin
            add_text_byte(CH_QUOTE);
            repeat (len)
            begin
                case ($urandom_range(9))
                    0, 1: b = CH_QUOTE;
                    2:    b = noise_byte();
                    default: b = 8'($urandom_range(255));
                endcase
                add_text_byte(b);
                if (b == CH_QUOTE)
                    add_text_byte(CH_QUOTE);
            end
            add_text_byte(CH_QUOTE);
        end
        else
        begin
            repeat (len)
                add_text_byte(plain_text_byte());
        end
    endtask

    task automatic build_stream(input bit drain);
        int unsigned nrec;
        int unsigned nfld;
        int unsigned shape;
        shape = $urandom_range(99);
        if (shape < 15)
        begin
            repeat ($urandom_range(1, 8))
                add_text_byte(noise_byte());
        end
        else
        begin
            nrec = $urandom_range(1, 3);
            for (int r = 0; r < nrec; r++)
            begin
                nfld = $urandom_range(1, 3);
                for (int f = 0; f < nfld; f++)
                begin
                    if (f > 0)
                        add_text_byte(CH_COMMA);
                    build_field();
                end
                if (r < nrec - 1 || $urandom_range(1))
                begin
                    case ($urandom_range(2))
                        0: add_text_byte(CH_LF);
                        1: add_text_byte(CH_CR);
                        default:
                        begin
                            add_text_byte(CH_CR);
                            add_text_byte(CH_LF);
                        end
                    endcase
                end
            end
            // broken record: a stray quote somewhere
            if (shape < 30)
                stream_buf.insert($urandom_range(stream_buf.size()), CH_QUOTE);
        end
        if (stream_buf.size() == 0)
            add_text_byte(plain_text_byte());
        flush_stream(drain);
    endtask

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                tokenize_byte(s_tdata, s_tlast);
                bytes_in++;
                if (s_tlast)
                    streams_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_text.size() > 0
                    && !(pending_text[0].drain && expected_tokens.size() > 0)
                    && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = pending_text.pop_front();
                    s_tdata  <= next_item.text;
                    s_tlast  <= next_item.eot;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                tokens_seen++;
                if (expected_tokens.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 0,
                                    32'({m_tuser, m_tdata, m_tlast}));
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("result_kind", 32'(want.kind), 32'(m_tuser));
                    if (m_tdata != want.data)
                        report_mismatch("cell_byte", 32'(want.data), 32'(m_tdata));
                    if (m_tlast != want.last)
                        report_mismatch("run_last", 32'(want.last), 32'(m_tlast));
                end
            end
            // long back-pressure so the run queue fills and the input stalls
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && bytes_in >= 60)
            begin
                hold_done <= 1'b1;
                hold_cnt  <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_tokens.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        // cell, field, quoted field with doubled quote, crlf, text at the end
        stream_buf = '{8'h61, CH_COMMA, CH_QUOTE, 8'h71, CH_QUOTE, CH_QUOTE, 8'h72,
                       CH_QUOTE, CH_CR, CH_LF, 8'h62};
        flush_stream(1'b0);
        // quote after cell text, then ignored bytes up to the end
        stream_buf = '{8'h78, CH_QUOTE, 8'h7A, 8'h7A};
        flush_stream(1'b0);
        // unclosed quote with extreme byte values
        stream_buf = '{CH_QUOTE, 8'h00, 8'hFF};
        flush_stream(1'b0);
        // pending quote closes the field at the end
        stream_buf = '{CH_QUOTE, CH_QUOTE};
        flush_stream(1'b0);
        // line feed after carriage return as the final byte
        stream_buf = '{CH_CR, CH_LF};
        flush_stream(1'b0);
        // single comma: three results from one byte
        stream_buf = '{CH_COMMA};
        flush_stream(1'b0);
        // error on the final byte
        stream_buf = '{8'h61, CH_QUOTE};
        flush_stream(1'b0);

        while (pending_text.size() < TARGET_BYTES)
            build_stream(streams_made == 15 || streams_made == 40);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_text.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("sent %0d text bytes in %0d streams, checked %0d results",
                 bytes_in, streams_in, tokens_seen);
        $display("mismatches: %0d", fail_cnt);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
